/* sv/hsv_saturation_boost_defines.svh */
// Assertion macros shared by the saturation boost modules.
`ifndef HSV_SATURATION_BOOST_DEFINES_SVH
`define HSV_SATURATION_BOOST_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define HSB_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define HSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define HSB_ASSERT(lbl, clk, rst_n, cond, msg)
`define HSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/hsb_pkg.sv */
// Types and constants shared by the saturation boost pipeline.
package hsb_pkg;

    // Fixed field widths.
    localparam int PIX_W  = 8;
    localparam int GAIN_W = 12;
    localparam int NUM_W  = 2 * PIX_W;

    // Default gain format and reset gain (1.5 with eight fraction bits).
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd384;

    // Divider: eight quotient bits, two per stage.
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = PIX_W / DIV_BITS;

    // Input register, sort, chroma, product, numerator; then divider; then output.
    localparam int FRONT_STAGES = 5;
    localparam int PIPE_LATENCY = FRONT_STAGES + DIV_STAGES + 1;

    // What a channel is within its pixel.
    typedef enum logic [1:0] {
        ROLE_MAX,
        ROLE_MIN,
        ROLE_MID
    } t_role;

    // Per-pixel data that travels alongside the arithmetic.
    typedef struct packed {
        t_role            role_red;
        t_role            role_green;
        t_role            role_blue;
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] lo;
        logic             last;
    } t_side;

endpackage

/* sv/hsb_div_pipe.sv */
// Pipelined restoring divider with an eight-bit quotient and side data.
`include "hsv_saturation_boost_defines.svh"

module hsb_div_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [hsb_pkg::NUM_W-1:0]  i_num,
    input  logic [hsb_pkg::PIX_W-1:0]  i_den,
    input  hsb_pkg::t_side             i_side,
    output logic                       o_vld,
    output logic [hsb_pkg::PIX_W-1:0]  o_quo,
    output hsb_pkg::t_side             o_side
);

    localparam int W      = hsb_pkg::PIX_W;
    localparam int STAGES = hsb_pkg::DIV_STAGES;

    typedef struct packed {
        logic           vld;
        logic [W-1:0]   rem;
        logic [W-1:0]   low;
        logic [W-1:0]   quo;
        logic [W-1:0]   den;
        hsb_pkg::t_side side;
    } t_div_stage;

    t_div_stage w_in;
    t_div_stage n_stg [STAGES];
    t_div_stage r_stg [STAGES];

    // The quotient fits in eight bits, so the upper half of the dividend is below the divisor.
    always_comb begin
        w_in.vld  = i_vld;
        w_in.rem  = i_num[2*W-1:W];
        w_in.low  = i_num[W-1:0];
        w_in.quo  = '0;
        w_in.den  = i_den;
        w_in.side = i_side;
    end

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            t_div_stage w_src;

            assign w_src = (s == 0) ? w_in : r_stg[(s > 0) ? s - 1 : 0];

            // Two shift and trial-subtract steps per stage.
            always_comb begin
                t_div_stage   cur;
                logic [W:0]   trial;
                cur   = w_src;
                trial = '0;
                for (int k = 0; k < hsb_pkg::DIV_BITS; k++) begin
                    trial   = {cur.rem, cur.low[W-1]};
                    cur.low = {cur.low[W-2:0], 1'b0};
                    if (trial >= {1'b0, cur.den}) begin
                        cur.rem = W'(trial - {1'b0, cur.den});
                        cur.quo = {cur.quo[W-2:0], 1'b1};
                    end else begin
                        cur.rem = trial[W-1:0];
                        cur.quo = {cur.quo[W-2:0], 1'b0};
                    end
                end
                n_stg[s] = cur;
            end

            // Stage register; only the valid bit is reset.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stg[s].vld <= 1'b0;
                end else begin
                    r_stg[s] <= n_stg[s];
                end
            end

            // The partial remainder must always stay below the divisor.
            `HSB_ASSERT_IMP(a_rem_below_den, i_clk, i_rst_n, r_stg[s].vld, r_stg[s].rem < r_stg[s].den, "divider remainder not below divisor")

            if (s > 0) begin : g_den_chk
                // The divisor travels unchanged from stage to stage.
                `HSB_ASSERT_IMP(a_den_kept, i_clk, i_rst_n, r_stg[s].vld, r_stg[s].den == $past(r_stg[s-1].den), "divisor changed inside divider")
            end
        end
    endgenerate

    assign o_vld  = r_stg[STAGES-1].vld;
    assign o_quo  = r_stg[STAGES-1].quo;
    assign o_side = r_stg[STAGES-1].side;

    // Each quotient that leaves belongs to operands that entered and passed through every stage register.
    `HSB_ASSERT_IMP(a_div_latency, i_clk, i_rst_n, o_vld, $past(i_vld, STAGES), "divider output without matching input")

endmodule

/* sv/hsv_saturation_boost.sv */
// Top level of the RGB888 saturation boost pipeline.
//
// Usage: a pixel is transferred in on a rising edge where start is high and busy is
// low. busy is high only during reset and the first cycle after it; otherwise a new
// pixel may be transferred in every cycle. Each pixel gives exactly one result,
// shown on the o_*_out ports for one cycle with o_result_valid high, in input order.
// Throughput is one pixel per clock. The depth is set by five front stages (input,
// sort, chroma multiply and clamp, middle-channel product, numerator), the four-stage
// two-bit-per-stage divider for the middle channel, and the output register. The
// receiver cannot stall, so the pipeline never holds.
// The gain register is written over the cfg channel (i_cfg_valid, o_cfg_ready) and
// must only change while no pixel is in flight. Reset empties the pipeline and sets
// the gain to 384 (1.5 with eight fraction bits).
`include "hsv_saturation_boost_defines.svh"

module hsv_saturation_boost #(
    parameter int GAIN_FRACTION_BITS = hsb_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [hsb_pkg::PIX_W-1:0]   i_red_in,
    input  logic [hsb_pkg::PIX_W-1:0]   i_green_in,
    input  logic [hsb_pkg::PIX_W-1:0]   i_blue_in,
    input  logic                        i_frame_end,
    output logic                        o_result_valid,
    output logic [hsb_pkg::PIX_W-1:0]   o_red_out,
    output logic [hsb_pkg::PIX_W-1:0]   o_green_out,
    output logic [hsb_pkg::PIX_W-1:0]   o_blue_out,
    output logic                        o_last_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hsb_pkg::GAIN_W-1:0]  i_cfg_saturation_gain
);

    localparam int F   = GAIN_FRACTION_BITS;
    localparam int W   = hsb_pkg::PIX_W;
    localparam int GW  = hsb_pkg::GAIN_W;
    localparam int MW  = W + GW;
    localparam int CW  = W + F;
    localparam int PW  = (MW > CW) ? MW : CW;
    localparam int TW  = CW + W;
    localparam int NW  = hsb_pkg::NUM_W;
    localparam int LAT = hsb_pkg::PIPE_LATENCY;

    localparam logic [CW-1:0] CS_ROUND = {{W{1'b0}}, {F{1'b1}}};
    localparam logic [TW-1:0] T_ROUND  = {{(TW-F){1'b0}}, {F{1'b1}}};

    function automatic hsb_pkg::t_role role_of(input logic [W-1:0] x,
                                               input logic [W-1:0] mx,
                                               input logic [W-1:0] mn);
        if (x == mx) begin
            return hsb_pkg::ROLE_MAX;
        end else if (x == mn) begin
            return hsb_pkg::ROLE_MIN;
        end else begin
            return hsb_pkg::ROLE_MID;
        end
    endfunction

    function automatic logic [W-1:0] chan_out(input hsb_pkg::t_role role,
                                              input logic [W-1:0]   mx,
                                              input logic [W-1:0]   lo,
                                              input logic [W-1:0]   mid);
        logic [W-1:0] res;
        unique case (role)
            hsb_pkg::ROLE_MAX: res = mx;
            hsb_pkg::ROLE_MIN: res = lo;
            hsb_pkg::ROLE_MID: res = mid;
            default:           res = mx;
        endcase
        return res;
    endfunction

    logic            w_accept;
    logic            r_busy;
    logic [GW-1:0]   r_gain;

    logic            r1_vld;
    logic [W-1:0]    r1_red, r1_green, r1_blue;
    logic            r1_last;

    logic [W-1:0]    w2_mx, w2_mn, w2_mid;
    hsb_pkg::t_side  w2_side;
    logic            r2_vld;
    hsb_pkg::t_side  r2_side;
    logic [W-1:0]    r2_delta, r2_dm;

    logic [MW-1:0]   w3_prod;
    logic [PW-1:0]   w3_prod_w, w3_limit_w;
    logic [CW-1:0]   w3_cs;
    logic            r3_vld;
    hsb_pkg::t_side  r3_side;
    logic [W-1:0]    r3_delta, r3_dm;
    logic [CW-1:0]   r3_cs;

    logic [CW-1:0]   w4_cs_round;
    hsb_pkg::t_side  w4_side;
    logic            r4_vld;
    hsb_pkg::t_side  r4_side;
    logic [W-1:0]    r4_delta;
    logic [TW-1:0]   r4_t;

    logic [TW-1:0]   w5_t_round;
    logic [NW-1:0]   w5_u;
    logic            r5_vld;
    hsb_pkg::t_side  r5_side;
    logic [NW-1:0]   r5_num;
    logic [W-1:0]    r5_den;

    logic            w_div_vld;
    logic [W-1:0]    w_div_quo;
    hsb_pkg::t_side  w_div_side;
    logic [W-1:0]    w_mid_out;

    logic            r_out_vld;
    logic [W-1:0]    r_red, r_green, r_blue;
    logic            r_last;

    // Handshake: held off only around reset.
    assign w_accept    = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Gain register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= hsb_pkg::GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gain <= i_cfg_saturation_gain;
        end
    end

    // Stage 1: input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_accept;
        end
        r1_red   <= i_red_in;
        r1_green <= i_green_in;
        r1_blue  <= i_blue_in;
        r1_last  <= i_frame_end;
    end

    // Stage 2: sort the channels and tag each one as maximum, minimum or middle.
    always_comb begin
        w2_mx = r1_red;
        if (r1_green > w2_mx) w2_mx = r1_green;
        if (r1_blue > w2_mx)  w2_mx = r1_blue;
        w2_mn = r1_red;
        if (r1_green < w2_mn) w2_mn = r1_green;
        if (r1_blue < w2_mn)  w2_mn = r1_blue;
        w2_side.role_red   = role_of(r1_red, w2_mx, w2_mn);
        w2_side.role_green = role_of(r1_green, w2_mx, w2_mn);
        w2_side.role_blue  = role_of(r1_blue, w2_mx, w2_mn);
        w2_side.mx         = w2_mx;
        w2_side.lo         = '0;
        w2_side.last       = r1_last;
        // With no strict middle channel the divider result is not used.
        priority if (w2_side.role_red == hsb_pkg::ROLE_MID) begin
            w2_mid = r1_red;
        end else if (w2_side.role_green == hsb_pkg::ROLE_MID) begin
            w2_mid = r1_green;
        end else if (w2_side.role_blue == hsb_pkg::ROLE_MID) begin
            w2_mid = r1_blue;
        end else begin
            w2_mid = w2_mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_side  <= w2_side;
        r2_delta <= w2_mx - w2_mn;
        r2_dm    <= w2_mx - w2_mid;
    end

    // Stage 3: scaled chroma delta*gain, clamped at the maximum channel.
    assign w3_prod    = MW'(r2_delta) * MW'(r_gain);
    assign w3_prod_w  = PW'(w3_prod);
    assign w3_limit_w = PW'({r2_side.mx, {F{1'b0}}});
    assign w3_cs      = (w3_prod_w > w3_limit_w) ? w3_limit_w[CW-1:0] : w3_prod_w[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_side  <= r2_side;
        r3_delta <= r2_delta;
        r3_dm    <= r2_dm;
        r3_cs    <= w3_cs;
    end

    // Stage 4: middle-channel product, and the minimum channel mx - ceil(chroma).
    assign w4_cs_round = r3_cs + CS_ROUND;

    // Side data for stage 4 with the minimum channel filled in.
    always_comb begin
        w4_side    = r3_side;
        w4_side.lo = r3_side.mx - w4_cs_round[CW-1:F];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_side    <= w4_side;
        r4_delta   <= r3_delta;
        r4_t       <= TW'(r3_cs) * TW'(r3_dm);
    end

    // Stage 5: dividend for ceil(ceil(t / 2^F) / delta); grey pixels divide zero by one.
    assign w5_t_round = r4_t + T_ROUND;
    assign w5_u       = w5_t_round[TW-1:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_side <= r4_side;
        if (r4_delta == '0) begin
            r5_num <= '0;
            r5_den <= W'(1);
        end else begin
            r5_num <= w5_u + NW'(r4_delta) - NW'(1);
            r5_den <= r4_delta;
        end
    end

    hsb_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_num   (r5_num),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_vld   (w_div_vld),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    // Output register: each channel picks its value by role.
    assign w_mid_out = w_div_side.mx - w_div_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_div_vld;
        end
        r_red   <= chan_out(w_div_side.role_red, w_div_side.mx, w_div_side.lo, w_mid_out);
        r_green <= chan_out(w_div_side.role_green, w_div_side.mx, w_div_side.lo, w_mid_out);
        r_blue  <= chan_out(w_div_side.role_blue, w_div_side.mx, w_div_side.lo, w_mid_out);
        r_last  <= w_div_side.last;
    end

    assign o_result_valid = r_out_vld;
    assign o_red_out      = r_red;
    assign o_green_out    = r_green;
    assign o_blue_out     = r_blue;
    assign o_last_out     = r_last;

    // A result appears exactly for each pixel transferred in, once it has passed the whole pipeline.
    `HSB_ASSERT(a_result_timing, i_clk, i_rst_n, o_result_valid == $past(w_accept, LAT), "result strobe does not match an input transfer")

    // The frame-end flag rides with its own pixel.
    `HSB_ASSERT_IMP(a_last_follows, i_clk, i_rst_n, w_accept, ##LAT (o_result_valid && o_last_out == $past(i_frame_end, LAT)), "frame-end flag out of step")

    // A grey pixel leaves unchanged.
    `HSB_ASSERT_IMP(a_grey_passes, i_clk, i_rst_n, w_accept && i_red_in == i_green_in && i_green_in == i_blue_in, ##LAT (o_red_out == $past(i_red_in, LAT) && o_blue_out == $past(i_blue_in, LAT)), "grey pixel altered")

endmodule

/* test/tb_hsv_saturation_boost.sv */
// Self-checking testbench for the RGB888 saturation boost pipeline.
module tb_hsv_saturation_boost;

    localparam int IDLE_LIMIT      = 2000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int FRAC            = hsb_pkg::GAIN_FRAC_BITS_DEF;
    localparam int PIX             = hsb_pkg::PIX_W;
    localparam int GW              = hsb_pkg::GAIN_W;

    // One pixel as it enters or leaves the block.
    typedef struct packed {
        logic [hsb_pkg::PIX_W-1:0] red;
        logic [hsb_pkg::PIX_W-1:0] green;
        logic [hsb_pkg::PIX_W-1:0] blue;
        logic                      last;
    } t_rgb_pixel;

    // Predicts the boosted pixel for every input transfer and checks results in order.
    class t_boost_scoreboard;
        logic [hsb_pkg::GAIN_W-1:0] gain;
        t_rgb_pixel                 expected_pixels[$];
        int unsigned                errors;
        int unsigned                pixels;
        int unsigned                grey_pixels;
        int unsigned                clamped_pixels;
        int unsigned                gain_writes;

        function new();
            gain           = hsb_pkg::GAIN_RESET;
            errors         = 0;
            pixels         = 0;
            grey_pixels    = 0;
            clamped_pixels = 0;
            gain_writes    = 0;
        endfunction

        function void set_gain(logic [hsb_pkg::GAIN_W-1:0] value);
            gain = value;
            gain_writes++;
        endfunction

        // Floor of mx - chroma * (mx - x) / delta, with chroma carrying the gain fraction.
        function logic [hsb_pkg::PIX_W-1:0] boosted_channel(longint unsigned x,
                                                            longint unsigned mx,
                                                            longint unsigned delta,
                                                            longint unsigned chroma);
            longint unsigned den;
            longint unsigned quot;
            den  = delta << FRAC;
            quot = (mx * den - chroma * (mx - x)) / den;
            return quot[hsb_pkg::PIX_W-1:0];
        endfunction

        function void note_pixel(t_rgb_pixel px);
            longint unsigned r;
            longint unsigned g;
            longint unsigned b;
            longint unsigned mx;
            longint unsigned mn;
            longint unsigned delta;
            longint unsigned chroma;
            longint unsigned limit;
            t_rgb_pixel      want;
            r = 64'(px.red);
            g = 64'(px.green);
            b = 64'(px.blue);
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            delta = mx - mn;
            want  = px;
            pixels++;
            if (delta == 0) begin
                // A grey pixel has no hue and passes through as it is.
                grey_pixels++;
            end else begin
                chroma = delta * 64'(gain);
                limit  = mx << FRAC;
                if (chroma > limit) begin
                    chroma = limit;
                    clamped_pixels++;
                end
                want.red   = boosted_channel(r, mx, delta, chroma);
                want.green = boosted_channel(g, mx, delta, chroma);
                want.blue  = boosted_channel(b, mx, delta, chroma);
            end
            expected_pixels.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_rgb_pixel got);
            t_rgb_pixel want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: result with no pixel pending, expected none, actual %h %h %h %b",
                         $time, got.red, got.green, got.blue, got.last);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red", 32'(want.red), 32'(got.red));
            compare_field("green", 32'(want.green), 32'(got.green));
            compare_field("blue", 32'(want.blue), 32'(got.blue));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                        i_clk                 = 1'b0;
    logic                        i_rst_n               = 1'b0;
    logic                        start                 = 1'b0;
    logic                        busy;
    logic [hsb_pkg::PIX_W-1:0]   i_red_in              = '0;
    logic [hsb_pkg::PIX_W-1:0]   i_green_in            = '0;
    logic [hsb_pkg::PIX_W-1:0]   i_blue_in             = '0;
    logic                        i_frame_end           = 1'b0;
    logic                        o_result_valid;
    logic [hsb_pkg::PIX_W-1:0]   o_red_out;
    logic [hsb_pkg::PIX_W-1:0]   o_green_out;
    logic [hsb_pkg::PIX_W-1:0]   o_blue_out;
    logic                        o_last_out;
    logic                        i_cfg_valid           = 1'b0;
    logic                        o_cfg_ready;
    logic [hsb_pkg::GAIN_W-1:0]  i_cfg_saturation_gain = '0;

    t_boost_scoreboard sb = new();
    bit                gaps_on = 1'b1;
    int unsigned       idle_cycles = 0;

    hsv_saturation_boost uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_red_in              (i_red_in),
        .i_green_in            (i_green_in),
        .i_blue_in             (i_blue_in),
        .i_frame_end           (i_frame_end),
        .o_result_valid        (o_result_valid),
        .o_red_out             (o_red_out),
        .o_green_out           (o_green_out),
        .o_blue_out            (o_blue_out),
        .o_last_out            (o_last_out),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_saturation_gain (i_cfg_saturation_gain)
    );

    // Clock with a period of 10 time units.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Observe every transfer at the clock edge and stop the run if the block goes quiet.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_gain(i_cfg_saturation_gain);
            if (start && !busy)
                sb.note_pixel('{i_red_in, i_green_in, i_blue_in, i_frame_end});
            if (o_result_valid)
                sb.check_result('{o_red_out, o_green_out, o_blue_out, o_last_out});
            if ((i_cfg_valid && o_cfg_ready) || (start && !busy) || o_result_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_hsv_saturation_boost: errors");
                $finish;
            end
        end
    end

    // Present one pixel, after a random gap while gaps_on is set, and return at the edge that transfers it.
    task automatic send_pixel(input logic [hsb_pkg::PIX_W-1:0] r,
                              input logic [hsb_pkg::PIX_W-1:0] g,
                              input logic [hsb_pkg::PIX_W-1:0] b,
                              input logic                      last);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 29) begin
                // Junk on the data lines while start is low must be ignored.
                start       <= 1'b0;
                i_red_in    <= PIX'($urandom);
                i_green_in  <= PIX'($urandom);
                i_blue_in   <= PIX'($urandom);
                i_frame_end <= 1'($urandom);
                @(posedge i_clk);
            end
        end
        start       <= 1'b1;
        i_red_in    <= r;
        i_green_in  <= g;
        i_blue_in   <= b;
        i_frame_end <= last;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and wait until every pending pixel has come back.
    task automatic drain_pipeline();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_pixels.size() != 0);
    endtask

    // Write the gain register while the pipeline is empty.
    task automatic write_gain(input logic [hsb_pkg::GAIN_W-1:0] value);
        drain_pipeline();
        i_cfg_valid           <= 1'b1;
        i_cfg_saturation_gain <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mix of grey, tied, saturated-corner and fully random pixels.
    function automatic t_rgb_pixel random_pixel();
        t_rgb_pixel                px;
        logic [hsb_pkg::PIX_W-1:0] a;
        logic [hsb_pkg::PIX_W-1:0] c;
        a       = PIX'($urandom);
        c       = PIX'($urandom);
        px.red   = PIX'($urandom);
        px.green = PIX'($urandom);
        px.blue  = PIX'($urandom);
        px.last  = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 9))
            0: begin
                px.red   = a;
                px.green = a;
                px.blue  = a;
            end
            1: begin
                px.red   = a;
                px.green = a;
                px.blue  = c;
            end
            2: begin
                px.red   = c;
                px.green = a;
                px.blue  = a;
            end
            3: begin
                px.red   = a;
                px.green = c;
                px.blue  = a;
            end
            4: begin
                px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: begin
            end
        endcase
        return px;
    endfunction

    initial begin
        t_rgb_pixel                 px;
        logic [hsb_pkg::GAIN_W-1:0] phase_gain;

        // Synchronous reset held low, then released.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels at the reset gain of 1.5.
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);  // black
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);  // white
        send_pixel(8'd77,  8'd77,  8'd77,  1'b0);  // mid grey
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);  // pure primaries
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b1);
        send_pixel(8'd200, 8'd100, 8'd50,  1'b0);  // chroma clamps at the value
        send_pixel(8'd200, 8'd180, 8'd170, 1'b0);  // gentle boost, no clamp
        send_pixel(8'd200, 8'd200, 8'd50,  1'b0);  // two channels tied at the max
        send_pixel(8'd200, 8'd50,  8'd50,  1'b0);  // two channels tied at the min
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0);  // smallest non-grey pixel
        send_pixel(8'd254, 8'd255, 8'd253, 1'b0);
        send_pixel(8'd255, 8'd128, 8'd0,   1'b1);
        send_pixel(8'd0,   8'd128, 8'd255, 1'b0);
        send_pixel(8'd17,  8'd240, 8'd99,  1'b0);
        send_pixel(8'd128, 8'd129, 8'd127, 1'b0);
        send_pixel(8'd85,  8'd170, 8'd255, 1'b1);
        send_pixel(8'd3,   8'd2,   8'd1,   1'b0);

        // Random pixels under a sequence of gain settings, extremes first.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       phase_gain = '0;
                1:       phase_gain = '1;
                2:       phase_gain = 12'd256;
                3:       phase_gain = 12'd1;
                4, 5:    phase_gain = GW'($urandom_range(128, 640));
                default: phase_gain = GW'($urandom_range(0, 4095));
            endcase
            write_gain(phase_gain);
            // One phase runs back to back with no gaps at all.
            gaps_on = (ph != 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                px = random_pixel();
                send_pixel(px.red, px.green, px.blue, px.last);
            end
        end
        gaps_on = 1'b1;

        drain_pipeline();
        repeat (hsb_pkg::PIPE_LATENCY + 2) @(posedge i_clk);

        $display("Checked %0d pixels across %0d gain settings, including gains 0 and 4095.",
                 sb.pixels, sb.gain_writes + 1);
        $display("Of those, %0d were grey and %0d had their chroma clamped at the value.",
                 sb.grey_pixels, sb.clamped_pixels);
        if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
            $display("tb_hsv_saturation_boost: clean");
        end else begin
            $display("%0d mismatches, %0d results still expected",
                     sb.errors, sb.expected_pixels.size());
            $display("tb_hsv_saturation_boost: errors");
        end
        $finish;
    end

endmodule
